[rtl/core/twff_pkg.sv]
// Shared types and constants for the time-window frame FIFO.
// Holds sequencer states, status, command and register-index codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package twff_pkg;

	localparam int unsigned DEF_FIFO_DEPTH       = 64;
	localparam int unsigned DEF_POINT_COUNT_BITS = 24;

	localparam int unsigned TIME_W   = 63;
	localparam int unsigned PORT_P_W = 24;
	localparam int unsigned FRAMES_W = 7;

	localparam logic [FRAMES_W-1:0] RST_MAX_FRAMES = 7'd64;
	localparam logic [PORT_P_W-1:0] RST_MAX_POINTS = 24'hFFFFFF;

	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_CLEAR    = 1'b1;
	localparam logic POLICY_REJECT = 1'b0;
	localparam logic POLICY_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		STAT_ACCEPTED = 2'd0,
		STAT_FLUSHED  = 2'd1,
		STAT_REJECTED = 2'd2,
		STAT_CLEARED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TIME_WINDOW = 2'd0,
		REG_MAX_FRAMES  = 2'd1,
		REG_MAX_POINTS  = 2'd2,
		REG_POLICY      = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_AGE,
		S_CAP,
		S_STORE,
		S_FINISH
	} state_t;

endpackage

[rtl/core/time_window_frame_fifo.sv]
// Time-window frame FIFO: ring of (timestamp, point count) records with age and capacity eviction.
// Depends on twff_pkg for state, status and register codes.
`timescale 1ns / 1ps

// Pulse start while busy is low to offer one word (add or clear). The block raises busy
// and works through one shared 64-bit subtractor and one ring read port: a clear or a
// rejected frame visits CHECK and FINISH; an added frame visits CHECK, AGE, CAP, STORE and
// FINISH, staying in AGE or CAP per evicted record (at most FIFO_DEPTH evictions), as the
// sequencer pops one record per cycle from the registered head read. The result is shown
// for exactly one cycle with done high, in the first cycle with busy low; it cannot be held
// off, so capture it then. A new start is taken in that same cycle. Configuration
// (cfg_valid/cfg_ready) is always ready and must only be written while busy is low and no result is pending.
module time_window_frame_fifo
	import twff_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH       = DEF_FIFO_DEPTH,
	parameter int unsigned POINT_COUNT_BITS = DEF_POINT_COUNT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [TIME_W-1:0]   frame_time,
	input  logic [PORT_P_W-1:0] frame_points,

	output logic                done,
	output logic [1:0]          status,
	output logic [PORT_P_W-1:0] offered_points,
	output logic [PORT_P_W-1:0] kept_points,
	output logic [FRAMES_W-1:0] dropped_frames,
	output logic [PORT_P_W-1:0] dropped_points,
	output logic [FRAMES_W-1:0] frames_held,
	output logic [PORT_P_W-1:0] points_held,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [TIME_W-1:0]   cfg_data
);

	localparam int unsigned P_W   = POINT_COUNT_BITS;
	localparam int unsigned IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned LIM_W = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
	localparam int unsigned DIF_W = TIME_W + 1;

	// configuration
	logic [TIME_W-1:0]   time_window_q;
	logic [FRAMES_W-1:0] max_frames_q;
	logic [P_W-1:0]      max_points_q;
	logic                policy_q;

	// sequencer and working state
	state_t              state_q, state_d;
	logic                cmd_q;
	logic [TIME_W-1:0]   t_q;
	logic [P_W-1:0]      offered_q;
	logic [P_W-1:0]      kept_q;
	status_t             status_q;
	logic [FRAMES_W-1:0] drop_frames_q;
	logic [PORT_P_W-1:0] drop_points_q;
	logic                done_q;

	// FIFO bookkeeping
	logic [IDX_W-1:0]    head_q, head_d, head_inc;
	logic [CNT_W-1:0]    frame_total_q;
	logic [P_W-1:0]      point_total_q;
	logic [TIME_W-1:0]   newest_time_q;
	logic                newest_valid_q;

	// ring storage
	logic [TIME_W-1:0]   time_mem [FIFO_DEPTH];
	logic [P_W-1:0]      pts_mem  [FIFO_DEPTH];
	logic [TIME_W-1:0]   rd_time_q;
	logic [P_W-1:0]      rd_points_q;

	logic                accept;
	logic [DIF_W-1:0]    sub_b;
	logic [DIF_W-1:0]    diff;
	logic                older;
	logic                age_over;
	logic                nonempty;
	logic [LIM_W-1:0]    limit;
	logic [P_W-1:0]      room;
	logic [P_W-1:0]      kept_calc;
	logic                pop_age, pop_cap, pop;
	logic                empty_now;
	logic                regress_drop;
	logic [SUM_W-1:0]    slot_sum;
	logic [IDX_W-1:0]    slot;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Shared subtractor: newest-timestamp check in CHECK, age of the head record otherwise.
	assign sub_b    = (state_q == S_CHECK) ? {1'b0, newest_time_q} : {1'b0, rd_time_q};
	assign diff     = {1'b0, t_q} - sub_b;
	assign older    = newest_valid_q && diff[DIF_W-1];
	assign age_over = diff > {1'b0, time_window_q};

	assign nonempty  = (frame_total_q != '0);
	assign kept_calc = (offered_q < max_points_q) ? offered_q : max_points_q;
	assign limit     = (LIM_W'(max_frames_q) < LIM_W'(FIFO_DEPTH)) ?
		LIM_W'(max_frames_q) : LIM_W'(FIFO_DEPTH);
	assign room      = max_points_q - kept_q;

	assign pop_age = (state_q == S_AGE) && nonempty && age_over;
	assign pop_cap = (state_q == S_CAP) && nonempty &&
		((LIM_W'(frame_total_q) >= limit) || (point_total_q > room));
	assign pop     = pop_age || pop_cap;

	assign regress_drop = older && (policy_q == POLICY_REJECT);
	assign empty_now    = (state_q == S_CHECK) &&
		((cmd_q == CMD_CLEAR) || (older && (policy_q == POLICY_FLUSH)));

	assign head_inc = (head_q == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	always_comb begin
		head_d = head_q;
		if (empty_now) begin
			head_d = '0;
		end else if (pop) begin
			head_d = head_inc;
		end
	end

	assign slot_sum = SUM_W'(head_q) + SUM_W'(frame_total_q);
	assign slot     = (slot_sum >= SUM_W'(FIFO_DEPTH)) ?
		IDX_W'(slot_sum - SUM_W'(FIFO_DEPTH)) : IDX_W'(slot_sum);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (cmd_q == CMD_CLEAR || regress_drop) state_d = S_FINISH;
				else state_d = S_AGE;
			end
			S_AGE: begin
				if (!pop_age) state_d = S_CAP;
			end
			S_CAP: begin
				if (!pop_cap) state_d = S_STORE;
			end
			S_STORE:  state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = (state_q != S_IDLE);
		done           = done_q;
		status         = status_q;
		offered_points = PORT_P_W'(offered_q);
		kept_points    = PORT_P_W'(kept_q);
		dropped_frames = drop_frames_q;
		dropped_points = drop_points_q;
		frames_held    = FRAMES_W'(frame_total_q);
		points_held    = PORT_P_W'(point_total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_window_q <= '0;
			max_frames_q  <= RST_MAX_FRAMES;
			max_points_q  <= P_W'(RST_MAX_POINTS);
			policy_q      <= POLICY_REJECT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TIME_WINDOW: time_window_q <= cfg_data;
				REG_MAX_FRAMES:  max_frames_q  <= cfg_data[FRAMES_W-1:0];
				REG_MAX_POINTS:  max_points_q  <= P_W'(cfg_data[PORT_P_W-1:0]);
				REG_POLICY:      policy_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cmd_q          <= CMD_ADD;
			t_q            <= '0;
			offered_q      <= '0;
			kept_q         <= '0;
			status_q       <= STAT_ACCEPTED;
			drop_frames_q  <= '0;
			drop_points_q  <= '0;
			done_q         <= 1'b0;
			head_q         <= '0;
			frame_total_q  <= '0;
			point_total_q  <= '0;
			newest_time_q  <= '0;
			newest_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			done_q  <= (state_q == S_FINISH);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q         <= command;
						t_q           <= frame_time;
						offered_q     <= P_W'(frame_points);
						kept_q        <= '0;
						drop_frames_q <= '0;
						drop_points_q <= '0;
					end
				end
				S_CHECK: begin
					if (empty_now) begin
						drop_frames_q  <= FRAMES_W'(frame_total_q);
						drop_points_q  <= PORT_P_W'(point_total_q);
						frame_total_q  <= '0;
						point_total_q  <= '0;
					end
					if (cmd_q == CMD_CLEAR) begin
						status_q       <= STAT_CLEARED;
						newest_valid_q <= 1'b0;
						newest_time_q  <= '0;
					end else if (regress_drop) begin
						status_q <= STAT_REJECTED;
					end else begin
						status_q       <= older ? STAT_FLUSHED : STAT_ACCEPTED;
						newest_time_q  <= t_q;
						newest_valid_q <= 1'b1;
						kept_q         <= kept_calc;
					end
				end
				S_AGE, S_CAP: begin
					// drop the head record
					if (pop) begin
						frame_total_q <= frame_total_q - CNT_W'(1);
						point_total_q <= point_total_q - rd_points_q;
						drop_frames_q <= drop_frames_q + FRAMES_W'(1);
						drop_points_q <= drop_points_q + PORT_P_W'(rd_points_q);
					end
				end
				S_STORE: begin
					if (kept_q != '0) begin
						frame_total_q <= frame_total_q + CNT_W'(1);
						point_total_q <= point_total_q + kept_q;
					end
				end
				S_FINISH: ;
				default: ;
			endcase
		end
	end

	// Ring storage: read the record that will be at the head next cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_STORE && kept_q != '0) begin
			time_mem[slot] <= t_q;
			pts_mem[slot]  <= kept_q;
		end
		rd_time_q   <= time_mem[head_d];
		rd_points_q <= pts_mem[head_d];
	end

endmodule
